/* src/assert_macros.svh */
// assertion macros for the vertex_duplicate_finder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define VDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/vdf_pkg.sv */
// shared types, constants and float compare for the vertex duplicate finder
`timescale 1ns / 1ps
package vdf_pkg;
    localparam int unsigned MAX_VERTICES_DEF = 1024;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned VTX_W = 3 * COORD_W;
    localparam int unsigned IDX_W = 10;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDQ,
        ST_WAITQ,
        ST_SCAN,
        ST_DONE
    } state_t;

    function automatic logic coord_is_nan(input logic [COORD_W-1:0] b);
        coord_is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        if (coord_is_nan(a) || coord_is_nan(b))
            coord_equal = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            coord_equal = 1'b1;
        else
            coord_equal = (a == b);
    endfunction

    function automatic logic vtx_equal(input logic [VTX_W-1:0] p,
                                       input logic [VTX_W-1:0] q);
        vtx_equal = coord_equal(p[31:0], q[31:0]) && coord_equal(p[63:32], q[63:32])
            && coord_equal(p[95:64], q[95:64]);
    endfunction
endpackage

/* src/vertex_duplicate_finder.sv */
// top level: load/query sequencer around the vertex memory and one comparator
//
// in channel: in_valid/in_stall with req_type, first, x/y/z_bits, query_index
// a load (req_type 0) is written in the cycle it is accepted and gives no transfer
// out; first clears the count and overflow flag before the write
// a query (req_type 1) yields one transfer on out_valid/out_stall with rep_index,
// in_range, is_duplicate and overflowed
// a query reads the queried vertex, then scans entries from index 0 upward, one
// memory read per cycle through the single registered read port, stopping at
// the first match or on reaching the queried index; an out-of-range query skips
// the read and the scan and its result is offered straight away
// the input is stalled while a query runs and while its result waits
// the result register holds while out_stall is high
// reset clears the count, the overflow flag and the sequencer; memory contents
// are undefined until loaded
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vertex_duplicate_finder #(
    parameter int unsigned MAX_VERTICES = vdf_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic                        first,
    input  logic [31:0]                 x_bits,
    input  logic [31:0]                 y_bits,
    input  logic [31:0]                 z_bits,
    input  logic [vdf_pkg::IDX_W-1:0]   query_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [vdf_pkg::IDX_W-1:0]   rep_index,
    output logic                        in_range,
    output logic                        is_duplicate,
    output logic                        overflowed
);
    localparam int unsigned AW = $clog2(MAX_VERTICES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned QW = (AW > vdf_pkg::IDX_W) ? AW : vdf_pkg::IDX_W;

    vdf_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [vdf_pkg::IDX_W-1:0] q_reg, q_next;
    logic [vdf_pkg::VTX_W-1:0] qv_reg, qv_next;
    logic [vdf_pkg::IDX_W-1:0] rep_reg, rep_next;
    logic inr_reg, inr_next;
    logic ovo_reg, ovo_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [vdf_pkg::VTX_W-1:0] rd_data;
    logic [CW-1:0] base_count;
    logic [QW:0] q_ext, cnt_ext, max_ext;
    logic accept;

    vdf_store #(.DEPTH(MAX_VERTICES)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data({z_bits, y_bits, x_bits}), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdf_pkg::ST_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        q_reg <= q_next;
        qv_reg <= qv_next;
        rep_reg <= rep_next;
        inr_reg <= inr_next;
        ovo_reg <= ovo_next;
    end

    assign in_stall = (state_reg != vdf_pkg::ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign base_count = first ? '0 : count_reg;
    assign q_ext = (QW+1)'(query_index);
    assign cnt_ext = (QW+1)'(count_reg);
    assign max_ext = (QW+1)'(MAX_VERTICES);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        scan_next = scan_reg;
        q_next = q_reg;
        qv_next = qv_reg;
        rep_next = rep_reg;
        inr_next = inr_reg;
        ovo_next = ovo_reg;
        wr_en = 1'b0;
        wr_addr = base_count[AW-1:0];
        rd_addr = scan_reg[AW-1:0];
        case (state_reg)
            vdf_pkg::ST_IDLE:
            begin
                rd_addr = AW'(query_index);
                if (accept && req_type == vdf_pkg::REQ_LOAD)
                begin
                    if (first)
                        ovf_next = 1'b0;
                    if (base_count >= CW'(MAX_VERTICES))
                    begin
                        ovf_next = 1'b1;
                        count_next = base_count;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        count_next = base_count + 1'b1;
                    end
                end
                else if (accept)
                begin
                    q_next = query_index;
                    rep_next = query_index;
                    ovo_next = ovf_reg;
                    scan_next = '0;
                    inr_next = (q_ext < cnt_ext) && (q_ext < max_ext);
                    if ((q_ext < cnt_ext) && (q_ext < max_ext))
                        state_next = vdf_pkg::ST_RDQ;
                    else
                        state_next = vdf_pkg::ST_DONE;
                end
            end
            vdf_pkg::ST_RDQ:
            begin
                qv_next = rd_data;
                rd_addr = '0;
                state_next = vdf_pkg::ST_WAITQ;
            end
            vdf_pkg::ST_WAITQ:
            begin
                rd_addr = '0;
                state_next = vdf_pkg::ST_SCAN;
            end
            vdf_pkg::ST_SCAN:
            begin
                rd_addr = AW'(scan_reg + 1'b1);
                if ((QW+1)'(scan_reg) >= (QW+1)'(q_reg))
                    state_next = vdf_pkg::ST_DONE;
                else if (vdf_pkg::vtx_equal(rd_data, qv_reg))
                begin
                    rep_next = vdf_pkg::IDX_W'(scan_reg);
                    state_next = vdf_pkg::ST_DONE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            vdf_pkg::ST_DONE:
            begin
                if (!out_stall)
                    state_next = vdf_pkg::ST_IDLE;
            end
            default: state_next = vdf_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == vdf_pkg::ST_DONE);
    assign rep_index = rep_reg;
    assign in_range = inr_reg;
    assign is_duplicate = (rep_reg != q_reg) && inr_reg;
    assign overflowed = ovo_reg;

    `VDF_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_VERTICES), "count exceeds depth")
    `VDF_ASSERT_IMP(a_dup_inrange, clk, rst_n, out_valid && is_duplicate, in_range, "duplicate out of range")
    `VDF_ASSERT_IMP(a_rep_below, clk, rst_n, out_valid, rep_index <= q_reg, "rep above query")
    `VDF_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(rep_index), "result dropped")
endmodule

/* src/vdf_store.sv */
// vertex memory with one write port and one registered read port
`timescale 1ns / 1ps
module vdf_store #(
    parameter int unsigned DEPTH = vdf_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [vdf_pkg::VTX_W-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [vdf_pkg::VTX_W-1:0]     rd_data
);
    logic [vdf_pkg::VTX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
